@@ src/rof_pkg.sv @@
// Package for the reprojection outlier filter: payload structs, verdict codes,
// widths and fixed constants. No dependencies.
package rof_pkg;

    localparam int WORDS_PER_CAM = 12;
    localparam int MIN_KEPT      = 2;

    typedef logic [1:0] t_verdict;
    localparam t_verdict VERDICT_KEPT   = 2'd0;
    localparam t_verdict VERDICT_BEHIND = 2'd1;
    localparam t_verdict VERDICT_ERROR  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [5:0]         camera;
        logic [3:0]         element;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] seen_u;
        logic signed [31:0] seen_v;
        logic               final_obs;
    } t_in_word;

    typedef struct packed {
        logic        keep;
        t_verdict    verdict;
        logic        end_of_track;
        logic        track_ok;
        logic [15:0] kept_total;
    } t_out_word;

endpackage

@@ src/reprojection_outlier_filter.sv @@
// Reprojection outlier filter top level: matrix store, sequencer, counter.
// Depends on rof_pkg and rof_mul.
//
// A matrix load word with camera and element in range is stored when accepted.
// An observation passes through S_PROJ for the 12 matrix reads and products
// through one shared 33x33 multiplier register, S_DIFF for the error terms and
// the scaled threshold, S_SQR for the three squares built from 32-bit partial
// products on the same multiplier, and S_DONE to form the result. A point behind
// the camera skips the squares. Results wait in an output register; a new word is
// taken only while the sequencer is idle and that register is empty.
module reprojection_outlier_filter #(
    parameter int NUM_CAMERAS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rof_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rof_pkg::t_out_word  o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);
    import rof_pkg::*;

    localparam int DEPTH = NUM_CAMERAS * WORDS_PER_CAM;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PROJ = 5'b00010,
        S_DIFF = 5'b00100,
        S_SQR  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;
    logic [31:0] r_max_error;
    t_in_word    r_in;
    logic        r_cam_ok;
    logic [4:0]  r_step;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [63:0] r_dx, r_dy;
    logic [63:0] r_ax, r_ay, r_ez;
    logic [129:0] r_lhs, r_rhs;
    logic [15:0] r_kept;
    logic        r_out_valid;
    t_out_word   r_out;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    rof_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    logic [AW-1:0] rd_addr;
    logic [AW:0]   base_addr;
    logic          in_acc;
    logic          cam_in;

    assign cam_in  = (32'(i_data.camera) < NUM_CAMERAS);
    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign base_addr = (AW+1)'(r_in.camera) * (AW+1)'(WORDS_PER_CAM);
    assign rd_addr   = AW'(base_addr + (AW+1)'(r_step));

    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.mode == 1'b0 && cam_in && i_data.element < 4'(WORDS_PER_CAM)) begin
            r_mem[AW'((AW+1)'(i_data.camera) * (AW+1)'(WORDS_PER_CAM)
                      + (AW+1)'(i_data.element))] <= i_data.word_value;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Step plan in S_PROJ: step k issues read k, which is registered in r_rd, then multiplied.
    // The translation word is multiplied by one so every word goes the same path.
    logic [3:0] pk;
    logic [3:0] rk;
    logic signed [31:0] coord;
    logic signed [49:0] flo;
    logic signed [49:0] sum_nx;
    logic signed [31:0] sat_v;
    always_comb begin
        pk = 4'(r_step - 5'd2);
        rk = 4'(r_step - 5'd1);
        case (rk[1:0])
            2'd0:    coord = r_in.point_x;
            2'd1:    coord = r_in.point_y;
            2'd2:    coord = r_in.point_z;
            default: coord = 32'sd65536;
        endcase
        mul_a = 33'(signed'(r_cam_ok ? r_rd : 32'd0));
        mul_b = 33'(coord);
        flo = 50'(mul_p >>> 16);
        sum_nx = r_acc + flo;
        if (sum_nx > 50'sd2147483647)       sat_v = 32'sh7fffffff;
        else if (sum_nx < -50'sd2147483648) sat_v = 32'sh80000000;
        else                                sat_v = sum_nx[31:0];
        case (r_state)
            S_DIFF: begin
                mul_a = 33'(r_step[0] ? r_in.seen_v : r_in.seen_u);
                mul_b = 33'(r_pz);
                if (r_step == 5'd2) begin
                    mul_a = {1'b0, r_max_error};
                end
            end
            S_SQR: begin
                case (r_step[1:0])
                    2'd0: begin mul_a = {1'b0, r_ax[31:0]};  mul_b = {1'b0, r_ax[31:0]};  end
                    2'd1: begin mul_a = {1'b0, r_ax[63:32]}; mul_b = {1'b0, r_ax[31:0]};  end
                    2'd2: begin mul_a = {1'b0, r_ax[63:32]}; mul_b = {1'b0, r_ax[63:32]}; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: ;
        endcase
    end

    // S_PROJ uses r_rd once it is loaded; gate products by a word-valid step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_error <= 32'd131072;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_max_error <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_data.mode) begin
                        r_in     <= i_data;
                        r_cam_ok <= cam_in;
                        r_step   <= '0;
                        r_acc    <= '0;
                        r_state  <= S_PROJ;
                    end
                end
                S_PROJ: begin
                    // word k read at step k, then registered in r_rd, then its product in the multiplier
                    r_step <= r_step + 5'd1;
                    if (r_step >= 5'd2) begin
                        if (pk[1:0] == 2'd3) begin
                            r_acc <= '0;
                            case (pk[3:2])
                                2'd0:    r_px <= sat_v;
                                2'd1:    r_py <= sat_v;
                                default: r_pz <= sat_v;
                            endcase
                        end else begin
                            r_acc <= sum_nx;
                        end
                    end
                    if (pk == 4'd11) begin
                        r_step  <= '0;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd1) r_dx <= (64'(r_px) <<< 16) - 64'(mul_p);
                    if (r_step == 5'd2) r_dy <= (64'(r_py) <<< 16) - 64'(mul_p);
                    if (r_step == 5'd3) begin
                        r_ez   <= mul_p[63:0];
                        r_ax   <= r_dx[63] ? 64'(-r_dx) : r_dx;
                        r_ay   <= r_dy[63] ? 64'(-r_dy) : r_dy;
                        r_lhs  <= '0;
                        r_rhs  <= '0;
                        r_step <= '0;
                        r_state <= (r_pz <= 0) ? S_DONE : S_SQR;
                    end
                end
                S_SQR: begin
                    // 3 passes (ax, ay, ez); a product is added in the step after it is issued
                    r_step <= r_step + 5'd1;
                    if (r_step[1:0] != 2'd0) begin
                        if (r_step[4:2] == 3'd2) begin
                            case (r_step[1:0])
                                2'd1: r_rhs <= r_rhs + 130'(mul_p[63:0]);
                                2'd2: r_rhs <= r_rhs + (130'(mul_p[63:0]) << 33);
                                default: r_rhs <= r_rhs + (130'(mul_p[63:0]) << 64);
                            endcase
                        end else begin
                            case (r_step[1:0])
                                2'd1: r_lhs <= r_lhs + 130'(mul_p[63:0]);
                                2'd2: r_lhs <= r_lhs + (130'(mul_p[63:0]) << 33);
                                default: r_lhs <= r_lhs + (130'(mul_p[63:0]) << 64);
                            endcase
                        end
                    end
                    if (r_step[1:0] == 2'd3) begin
                        r_ax <= (r_step[4:2] == 3'd0) ? r_ay : r_ez;
                        if (r_step[4:2] == 3'd2) r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    logic        kept;
                    logic [15:0] cnt;
                    kept = (r_pz > 0) && (r_lhs <= r_rhs);
                    cnt  = (kept && r_kept != 16'hffff) ? r_kept + 16'd1 : r_kept;
                    r_out.keep         <= kept;
                    r_out.verdict      <= (r_pz <= 0) ? VERDICT_BEHIND
                                        : (kept ? VERDICT_KEPT : VERDICT_ERROR);
                    r_out.end_of_track <= r_in.final_obs;
                    r_out.track_ok     <= r_in.final_obs && (cnt >= 16'(MIN_KEPT));
                    r_out.kept_total   <= cnt;
                    r_kept      <= r_in.final_obs ? 16'd0 : cnt;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_acc) else $error("accept while busy");
    a_keep_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.keep == (o_data.verdict == VERDICT_KEPT)))
        else $error("keep and verdict disagree");
    a_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.track_ok) |-> o_data.end_of_track)
        else $error("track_ok off last");
`endif
endmodule

@@ src/rof_mul.sv @@
// Shared 33x33 signed multiplier with registered product for the filter.
// Depends on nothing.
module rof_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

@@ dv/reprojection_outlier_filter_tb.sv @@
// Testbench for reprojection_outlier_filter: directed and random matrix loads and
// observations, scoreboarded against an in-bench projection and error-test predictor.
// Depends on rof_pkg and the filter RTL.
module reprojection_outlier_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rof_pkg::*;

    localparam int NUM_CAMS = 64;
    localparam int NUM_USED = 16;
    localparam int IN_W     = $bits(t_in_word);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_vld = 1'b0;
    t_in_word    in_word = '0;
    logic        out_stall = 1'b1;
    logic        cfg_vld = 1'b0;
    logic [31:0] cfg_word = '0;
    logic        o_stall, o_valid, o_cfg_ready;
    t_out_word   o_data;

    reprojection_outlier_filter #(.NUM_CAMERAS(NUM_CAMS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_vld), .o_stall(o_stall), .i_data(in_word),
        .o_valid(o_valid), .i_stall(out_stall), .o_data(o_data),
        .i_cfg_valid(cfg_vld), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_word)
    );

    // predictor state
    logic signed [31:0] cam_mat [NUM_CAMS][WORDS_PER_CAM];
    logic [15:0]        kept_cnt = '0;
    logic [31:0]        max_err = 32'd131072;

    t_in_word  pend_q[$];
    t_out_word verdict_q[$];
    int        errors = 0;
    int        idle_pct = 31;

    task automatic add_item(t_in_word w);
        pend_q.insert(pend_q.size(), w);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint proj_row(int cam, int r, longint x, longint y, longint z);
        longint s;
        s = ((longint'(cam_mat[cam][r*4]) * x) >>> 16)
          + ((longint'(cam_mat[cam][r*4+1]) * y) >>> 16)
          + ((longint'(cam_mat[cam][r*4+2]) * z) >>> 16)
          + longint'(cam_mat[cam][r*4+3]);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    function automatic t_out_word check_obs(t_in_word w);
        t_out_word   r;
        longint      px, py, pz, dx, dy;
        logic [129:0] ax, ay, ez, lhs, rhs;
        px = proj_row(w.camera, 0, w.point_x, w.point_y, w.point_z);
        py = proj_row(w.camera, 1, w.point_x, w.point_y, w.point_z);
        pz = proj_row(w.camera, 2, w.point_x, w.point_y, w.point_z);
        r = '0;
        if (pz <= 0) begin
            r.verdict = VERDICT_BEHIND;
        end else begin
            dx = px * 65536 - longint'(w.seen_u) * pz;
            dy = py * 65536 - longint'(w.seen_v) * pz;
            ax = dx < 0 ? 130'(-dx) : 130'(dx);
            ay = dy < 0 ? 130'(-dy) : 130'(dy);
            ez = 130'(max_err) * 130'(pz);
            lhs = ax * ax + ay * ay;
            rhs = ez * ez;
            r.verdict = (lhs <= rhs) ? VERDICT_KEPT : VERDICT_ERROR;
        end
        if (r.verdict == VERDICT_KEPT && kept_cnt != 16'hFFFF) kept_cnt = kept_cnt + 1'b1;
        r.keep = (r.verdict == VERDICT_KEPT);
        r.end_of_track = w.final_obs;
        r.track_ok = w.final_obs && kept_cnt >= MIN_KEPT;
        r.kept_total = kept_cnt;
        if (w.final_obs) kept_cnt = '0;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic     nv;
        t_in_word nd;
        nv = in_vld;
        nd = in_word;
        if (in_vld && !o_stall) begin
            if (in_word.mode) begin
                verdict_q.insert(verdict_q.size(), check_obs(in_word));
            end else if (in_word.element < WORDS_PER_CAM) begin
                cam_mat[in_word.camera][in_word.element] = in_word.word_value;
            end
            nv = 1'b0;
        end
        if (!nv && i_rst_n && pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nd = pend_q.pop_front();
            nv = 1'b1;
        end
        in_vld <= nv;
        in_word <= nd;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (o_valid && !out_stall && i_rst_n) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word, actual %p", $time, o_data);
                errors++;
            end else begin
                e = verdict_q.pop_front();
                if (o_data.keep !== e.keep || o_data.verdict !== e.verdict
                        || o_data.end_of_track !== e.end_of_track
                        || o_data.track_ok !== e.track_ok
                        || o_data.kept_total !== e.kept_total) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, e, o_data);
                    errors++;
                end
            end
        end
        out_stall <= i_rst_n ? ($urandom_range(99) < idle_pct) : 1'b1;
    end

    function automatic t_in_word mk_load(int cam, int elem, logic [31:0] val);
        t_in_word w;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.mode = 1'b0;
        w.camera = 6'(cam);
        w.element = 4'(elem);
        w.word_value = val;
        return w;
    endfunction

    function automatic t_in_word mk_obs(int cam, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] u, logic [31:0] v,
                                        logic last);
        t_in_word w;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.mode = 1'b1;
        w.camera = 6'(cam);
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        w.seen_u = u;
        w.seen_v = v;
        w.final_obs = last;
        return w;
    endfunction

    task automatic load_cam(int cam, logic [31:0] m [12]);
        for (int i = 0; i < WORDS_PER_CAM; i++) add_item(mk_load(cam, i, m[i]));
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || in_vld || verdict_q.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_max_err(logic [31:0] val);
        @(posedge i_clk);
        cfg_vld <= 1'b1;
        cfg_word <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_vld <= 1'b0;
        max_err = val;
    endtask

    task automatic rand_cam(int cam);
        logic [31:0] m [12];
        int f;
        f = $urandom_range(200, 2000);
        m = '{f << 16, 0, $urandom_range(0, 1000) << 16, $urandom_range(0, 65535),
              0, f << 16, $urandom_range(0, 1000) << 16, $urandom_range(0, 65535),
              $urandom_range(0, 255), $urandom_range(0, 255), 65536, $urandom_range(0, 65535)};
        load_cam(cam, m);
    endtask

    // observation of a sane camera near the error threshold
    function automatic t_in_word near_obs(int cam, logic last);
        longint x, y, z, px, py, pz, u, v;
        x = $signed($urandom_range(0, 2 << 20)) - (1 << 20);
        y = $signed($urandom_range(0, 2 << 20)) - (1 << 20);
        z = $urandom_range(1 << 16, 50 << 16);
        px = proj_row(cam, 0, x, y, z);
        py = proj_row(cam, 1, x, y, z);
        pz = proj_row(cam, 2, x, y, z);
        u = pz > 0 ? (px * 65536) / pz : 0;
        v = pz > 0 ? (py * 65536) / pz : 0;
        u += $signed($urandom_range(0, 6 << 16)) - (3 << 16);
        v += $signed($urandom_range(0, 6 << 16)) - (3 << 16);
        return mk_obs(cam, 32'(x), 32'(y), 32'(z), 32'(u), 32'(v), last);
    endfunction

    initial begin
        logic [31:0] ident [12];
        logic [31:0] wild [12];
        int          k;
        ident = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0};
        wild = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF,
                 32'h00010000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        load_cam(0, ident);
        load_cam(63, wild);
        add_item(mk_load(0, 12, 32'hFFFFFFFF));
        add_item(mk_load(0, 15, 32'h80000000));
        add_item(mk_obs(0, 5 << 16, 7 << 16, 1 << 16, 5 << 16, 7 << 16, 0));
        add_item(mk_obs(0, 5 << 16, 7 << 16, 1 << 16, 7 << 16, 7 << 16, 0));
        add_item(mk_obs(0, 5 << 16, 7 << 16, 1 << 16, (7 << 16) + 1, 7 << 16, 0));
        add_item(mk_obs(0, 1, 1, 0, 0, 0, 0));
        add_item(mk_obs(0, 1, 1, 32'h80000000, 0, 0, 1));
        add_item(mk_obs(63, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF, 0));
        add_item(mk_obs(63, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h80000000, 1));
        add_item(mk_obs(0, 3 << 16, 3 << 16, 2 << 16, 3 << 16, 3 << 16, 1));
        add_item(mk_obs(0, 3 << 16, 3 << 16, 2 << 16, 3 << 16, 3 << 16, 1));
        drain();
        set_max_err(32'd0);
        add_item(mk_obs(0, 5 << 16, 7 << 16, 1 << 16, 5 << 16, 7 << 16, 0));
        add_item(mk_obs(0, 5 << 16, 7 << 16, 1 << 16, (5 << 16) + 1, 7 << 16, 1));
        drain();
        set_max_err(32'hFFFFFFFF);
        add_item(mk_obs(0, 0, 0, 1 << 16, 32'h7FFFFFFF, 32'h80000000, 0));
        add_item(mk_obs(63, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 1));
        drain();
        set_max_err(32'd131072);

        // random: a set of cameras loaded, then phases that change the threshold or the idle rate
        for (int c = 0; c < NUM_USED; c++) rand_cam(c);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) set_max_err($urandom_range(0, 8 << 16));
            if (ph == 2) idle_pct = 0;
            if (ph == 3) begin
                idle_pct = 31;
                set_max_err($urandom);
            end
            for (int i = 0; i < 110; i++) begin
                k = $urandom_range(99);
                if (k < 75) begin
                    add_item(near_obs($urandom_range(NUM_USED - 1),
                                      $urandom_range(3) == 0));
                end else if (k < 85) begin
                    add_item(mk_obs($urandom_range(NUM_USED - 1), $urandom,
                                    $urandom, $urandom, $urandom, $urandom,
                                    1'($urandom_range(1))));
                end else if (k < 92) begin
                    rand_cam($urandom_range(NUM_USED - 1));
                end else begin
                    add_item(mk_load($urandom_range(NUM_CAMS - 1),
                                     $urandom_range(15), $urandom));
                end
                while (pend_q.size() > 32) @(posedge i_clk);
            end
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
